// ----- hw/rtl/prt_pkg.sv -----
`default_nettype none
package prt_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SWEEP_CAP = 64;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_DELIVER = 3'd1,
        KIND_POLL = 3'd2,
        KIND_ABANDON = 3'd3,
        KIND_DELETE = 3'd4,
        KIND_SWEEP = 3'd5
    } kind_t;

    localparam logic CFG_TABLE_LIMIT = 1'b0;
    localparam logic CFG_GRANT_CODE = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [63:0] req_id;
        logic [3:0] src_node;
        logic [3:0] dst_node;
        logic [15:0] req_op;
        logic [31:0] epoch_num;
        logic [62:0] time_value;
        logic [31:0] reply_code;
        logic [31:0] reject_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [31:0] verdict_code;
        logic [31:0] verdict_reason;
        logic [6:0] swept_count;
        logic [6:0] live_count;
    } out_item_t;

    typedef struct packed {
        logic [63:0] req_id;
        logic [3:0] src;
        logic [3:0] dst;
        logic [15:0] req_op;
        logic [31:0] epoch;
        logic [62:0] deadline;
        logic ready;
        logic abandoned;
        logic [31:0] reply;
        logic [31:0] reason;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CHK,
        ST_EVICT,
        ST_FREE,
        ST_ACT_REQ,
        ST_ACT,
        ST_WRITE,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/prt_ram.sv -----
`default_nettype none
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pending_reply_table_unit.sv -----
// Channel   Signals                                    Direction  Item
// cmd       start, busy, cmd                           in         in_item_t
// result    done, result                               out        out_item_t
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         table_limit, grant_code
//
// Each item scans the entry memory one slot per cycle; an insert that must evict scans it twice.
// An insert then finds a free slot and writes it. The single read port of the entry memory sets the scan rate.
// Reset clears the used bits and counters at once; there is no clearing pass.
// busy is high from acceptance until the done cycle; results cannot be stalled.
`default_nettype none
module pending_reply_table_unit (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    output logic busy,
    input wire prt_pkg::in_item_t cmd,
    output logic done,
    output prt_pkg::out_item_t result,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic cfg_index,
    input wire logic [31:0] cfg_data
);
    import prt_pkg::*;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [63:0] reclaimed_reg, reclaimed_next;
    logic [6:0] limit_reg;
    logic [31:0] grant_reg;
    logic [IDX_W:0] idx_reg, idx_next;
    logic hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic vic_reg, vic_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [62:0] vic_dl_reg, vic_dl_next;
    logic evicted_reg, evicted_next;
    logic [6:0] swept_reg, swept_next;
    logic [1:0] status_reg, status_next;
    logic [31:0] vc_reg, vc_next, vr_reg, vr_next;
    logic evict_phase_reg, evict_phase_next;
    out_item_t result_reg, result_next;
    logic done_reg, done_next;

    logic we;
    logic [IDX_W-1:0] waddr, raddr, ridx_reg;
    entry_t wdata, rdata;
    logic [CNT_W-1:0] lim;
    logic key_match;
    entry_t upd;

    prt_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done = done_reg;
    assign result = result_reg;
    assign lim = (limit_reg > 7'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(limit_reg);
    assign key_match = rdata.req_id == item_reg.req_id && rdata.src == item_reg.src_node
        && rdata.dst == item_reg.dst_node && rdata.req_op == item_reg.req_op
        && rdata.epoch == item_reg.epoch_num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            occ_reg <= '0;
            reclaimed_reg <= '0;
            limit_reg <= 7'd64;
            grant_reg <= 32'd1;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            occ_reg <= occ_next;
            reclaimed_reg <= reclaimed_next;
            done_reg <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TABLE_LIMIT)
                begin
                    limit_reg <= cfg_data[6:0];
                end
                else
                begin
                    grant_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg <= idx_next;
        ridx_reg <= raddr;
        hit_reg <= hit_next;
        hit_idx_reg <= hit_idx_next;
        vic_reg <= vic_next;
        vic_idx_reg <= vic_idx_next;
        vic_dl_reg <= vic_dl_next;
        evicted_reg <= evicted_next;
        swept_reg <= swept_next;
        status_reg <= status_next;
        vc_reg <= vc_next;
        vr_reg <= vr_next;
        evict_phase_reg <= evict_phase_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        used_next = used_reg;
        occ_next = occ_reg;
        reclaimed_next = reclaimed_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        vic_next = vic_reg;
        vic_idx_next = vic_idx_reg;
        vic_dl_next = vic_dl_reg;
        evicted_next = evicted_reg;
        swept_next = swept_reg;
        status_next = status_reg;
        vc_next = vc_reg;
        vr_next = vr_reg;
        evict_phase_next = evict_phase_reg;
        result_next = result_reg;
        done_next = 1'b0;
        we = 1'b0;
        waddr = hit_idx_reg;
        wdata = rdata;
        raddr = idx_reg[IDX_W-1:0];
        upd = rdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = cmd;
                    idx_next = '0;
                    hit_next = 1'b0;
                    vic_next = 1'b0;
                    evicted_next = 1'b0;
                    swept_next = '0;
                    status_next = '0;
                    vc_next = '0;
                    vr_next = '0;
                    evict_phase_next = 1'b0;
                    if (cmd.kind > 3'(KIND_SWEEP))
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmd.kind == 3'(KIND_INSERT) && occ_reg >= lim)
                    begin
                        evict_phase_next = 1'b1;
                        state_next = ST_SCAN_REQ;
                    end
                    else
                    begin
                        state_next = ST_SCAN_REQ;
                    end
                end
            end
            ST_SCAN_REQ:
            begin
                raddr = idx_reg[IDX_W-1:0];
                idx_next = idx_reg + 1'b1;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                raddr = idx_reg[IDX_W-1:0];
                if (used_reg[ridx_reg])
                begin
                    if (evict_phase_reg)
                    begin
                        if (rdata.abandoned && (!vic_reg || rdata.deadline < vic_dl_reg))
                        begin
                            vic_next = 1'b1;
                            vic_idx_next = ridx_reg;
                            vic_dl_next = rdata.deadline;
                        end
                    end
                    else if (item_reg.kind == 3'(KIND_SWEEP))
                    begin
                        if (rdata.abandoned && rdata.deadline != '0
                            && rdata.deadline <= item_reg.time_value
                            && swept_reg < 7'(SWEEP_CAP))
                        begin
                            used_next[ridx_reg] = 1'b0;
                            if (occ_next != '0)
                            begin
                                occ_next = occ_next - 1'b1;
                            end
                            swept_next = swept_reg + 1'b1;
                        end
                    end
                    else if (!hit_reg && key_match)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = ridx_reg;
                    end
                end
                if (idx_reg == (IDX_W+1)'(ENTRIES))
                begin
                    state_next = evict_phase_reg ? ST_EVICT : ST_ACT_REQ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EVICT:
            begin
                evict_phase_next = 1'b0;
                idx_next = '0;
                hit_next = 1'b0;
                if (vic_next)
                begin
                    used_next[vic_idx_reg] = 1'b0;
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                    reclaimed_next = reclaimed_reg + 64'd1;
                    vic_next = 1'b0;
                    if (!evicted_reg)
                    begin
                        evicted_next = 1'b1;
                        state_next = (item_reg.kind == 3'(KIND_INSERT) && hit_reg)
                            ? ST_FREE : ST_SCAN_REQ;
                    end
                    else
                    begin
                        state_next = ST_FREE;
                    end
                end
                else
                begin
                    status_next = 2'd2;
                    state_next = evicted_reg ? ST_FREE : ST_DONE;
                end
            end
            ST_FREE:
            begin
                hit_next = 1'b0;
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!used_reg[i])
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = IDX_W'(i);
                    end
                end
                if (hit_next)
                begin
                    status_next = evicted_reg ? 2'd1 : 2'd0;
                    state_next = ST_WRITE;
                end
                else if (!evicted_reg)
                begin
                    evict_phase_next = 1'b1;
                    idx_next = '0;
                    evicted_next = 1'b1;
                    vic_next = 1'b0;
                    state_next = ST_SCAN_REQ;
                end
                else
                begin
                    status_next = 2'd2;
                    state_next = ST_DONE;
                end
            end
            ST_ACT_REQ:
            begin
                raddr = hit_idx_reg;
                state_next = ST_ACT;
                if (item_reg.kind == 3'(KIND_INSERT))
                begin
                    if (hit_reg)
                    begin
                        status_next = 2'd3;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FREE;
                    end
                end
                else if (item_reg.kind == 3'(KIND_SWEEP))
                begin
                    reclaimed_next = reclaimed_reg + 64'(swept_reg);
                    state_next = ST_DONE;
                end
                else if (!hit_reg)
                begin
                    case (item_reg.kind)
                        3'(KIND_POLL): status_next = 2'd3;
                        3'(KIND_DELETE): status_next = 2'd1;
                        default: status_next = 2'd2;
                    endcase
                    state_next = ST_DONE;
                end
            end
            ST_ACT:
            begin
                state_next = ST_DONE;
                upd = rdata;
                case (item_reg.kind)
                    3'(KIND_DELIVER):
                    begin
                        if (rdata.abandoned)
                        begin
                            status_next = (item_reg.reply_code == grant_reg) ? 2'd1 : 2'd2;
                            used_next[hit_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            upd.reply = item_reg.reply_code;
                            upd.reason = item_reg.reject_code;
                            upd.ready = 1'b1;
                            we = 1'b1;
                        end
                    end
                    3'(KIND_POLL):
                    begin
                        if (rdata.abandoned)
                        begin
                            status_next = 2'd2;
                        end
                        else if (!rdata.ready)
                        begin
                            status_next = 2'd1;
                        end
                        else
                        begin
                            vc_next = rdata.reply;
                            vr_next = rdata.reason;
                            used_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    3'(KIND_ABANDON):
                    begin
                        if (rdata.ready && rdata.reply == grant_reg)
                        begin
                            used_next[hit_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            upd.abandoned = 1'b1;
                            upd.deadline = item_reg.time_value;
                            we = 1'b1;
                            status_next = 2'd1;
                        end
                    end
                    default:
                    begin
                        used_next[hit_idx_reg] = 1'b0;
                    end
                endcase
                if (!used_next[hit_idx_reg] && occ_reg != '0)
                begin
                    occ_next = occ_reg - 1'b1;
                end
                wdata = upd;
            end
            ST_WRITE:
            begin
                we = 1'b1;
                wdata = '{req_id: item_reg.req_id, src: item_reg.src_node,
                    dst: item_reg.dst_node, req_op: item_reg.req_op,
                    epoch: item_reg.epoch_num, deadline: item_reg.time_value,
                    ready: 1'b0, abandoned: 1'b0, reply: 32'd0, reason: 32'd0};
                used_next[hit_idx_reg] = 1'b1;
                occ_next = occ_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                result_next = '{status: status_reg, verdict_code: vc_reg,
                    verdict_reason: vr_reg, swept_count: swept_reg,
                    live_count: 7'(occ_reg)};
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
